// ===== rtl/lgs_pkg.sv =====
// Shared types and constants for the life grid generation step unit.
// No dependencies; every other file imports this package.
package lgs_pkg;

	localparam int GRID_SIZE = 32;
	localparam int ADDR_W    = $clog2(GRID_SIZE);
	localparam int COORD_W   = 5;
	// step counter runs 0 .. GRID_SIZE+1
	localparam int STEP_W    = $clog2(GRID_SIZE + 2);
	localparam int CNT_W     = 4;

	// neighbor counts of the B3/S23 rule
	localparam logic [CNT_W-1:0] BIRTH_COUNT   = CNT_W'(3);
	localparam logic [CNT_W-1:0] SURVIVE_COUNT = CNT_W'(2);

	typedef logic [GRID_SIZE-1:0] row_t;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_TICK  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_READ  = 5'b00010,
		S_WRITE = 5'b00100,
		S_TICK  = 5'b01000,
		S_CLEAR = 5'b10000
	} state_t;

endpackage

// ===== rtl/lgs_if.sv =====
// Channel interfaces: operation items in, result items out.
// Depends on lgs_pkg for field widths.
interface lgs_in_if;
	import lgs_pkg::*;
	logic               valid;
	logic               ready;
	logic [1:0]         operation;
	logic [COORD_W-1:0] row;
	logic [COORD_W-1:0] column;
	logic               cell_value;
	modport source (output valid, operation, row, column, cell_value, input ready);
	modport sink   (input valid, operation, row, column, cell_value, output ready);
endinterface

interface lgs_out_if;
	logic valid;
	logic ready;
	logic read_value;
	logic changed;
	logic grid_empty;
	modport source (output valid, read_value, changed, grid_empty, input ready);
	modport sink   (input valid, read_value, changed, grid_empty, output ready);
endinterface

// ===== rtl/lgs_row_rule.sv =====
// One row of the B3/S23 rule: next row from the rows above, at and below.
// Depends on lgs_pkg; cells beyond the left and right edges count as dead.
module lgs_row_rule (
	input  lgs_pkg::row_t above,
	input  lgs_pkg::row_t center,
	input  lgs_pkg::row_t below,
	output lgs_pkg::row_t next_row
);
	import lgs_pkg::*;

	// pad one dead cell on each side
	logic [GRID_SIZE+1:0] a_pad, c_pad, b_pad;

	assign a_pad = {1'b0, above, 1'b0};
	assign c_pad = {1'b0, center, 1'b0};
	assign b_pad = {1'b0, below, 1'b0};

	always_comb begin
		logic [CNT_W-1:0] cnt;
		for (int c = 0; c < GRID_SIZE; c++) begin
			cnt = CNT_W'(a_pad[c]) + CNT_W'(a_pad[c+1]) + CNT_W'(a_pad[c+2])
				+ CNT_W'(c_pad[c]) + CNT_W'(c_pad[c+2])
				+ CNT_W'(b_pad[c]) + CNT_W'(b_pad[c+1]) + CNT_W'(b_pad[c+2]);
			next_row[c] = (cnt == BIRTH_COUNT) || (center[c] && cnt == SURVIVE_COUNT);
		end
	end

endmodule

// ===== rtl/life_grid_generation_step_unit.sv =====
// Top level of the life grid generation step unit: grid row memory, sequencer
// and output register. Depends on lgs_pkg, lgs_in_if/lgs_out_if, lgs_row_rule.
//
//  channel | dir | carries
//  --------+-----+------------------------------------------------
//  item    | in  | operation, row, column, cell_value
//  result  | out | read_value, changed, grid_empty
//
// Read and write: accept, then row read and result; clear: accept, then result.
// A tick: the accept, then steps 0 .. GRID_SIZE+1 of the single row-rule unit
// that the sequencer walks down the grid one row a cycle through the row memory
// (one read and one write port).
// One item is in work at a time; item.ready is high only while idle.
// A result waits in the output register; the next item is accepted meanwhile
// and stalls only at its final cycle.
// Reset clears per-row valid bits, so the grid reads as all dead at once.
module life_grid_generation_step_unit (
	input  logic clk,
	input  logic arst_n,
	lgs_in_if.sink    item,
	lgs_out_if.source result
);
	import lgs_pkg::*;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GRID_SIZE + 1);
	localparam logic [STEP_W-1:0] ROWS      = STEP_W'(GRID_SIZE);

	state_t state_q;

	// captured item
	logic [COORD_W-1:0] row_q, col_q;
	logic               val_q;

	// row memory with per-row valid bits
	row_t                mem_q [GRID_SIZE];
	logic [GRID_SIZE-1:0] row_vld_q;
	row_t                rdata_q;
	logic                rd_vld_q;
	row_t                rdata;
	logic                mem_re, mem_we;
	logic [ADDR_W-1:0]   mem_ra, mem_wa;
	row_t                mem_wd;

	// tick window
	logic [STEP_W-1:0] step_q;
	row_t              prev_q, cur_q, below, next_row;
	logic              live_q;

	// output register
	logic out_valid_q, rd_value_q, chg_q, emp_q;
	logic slot_free, in_fire, load;
	logic res_rd, res_chg, res_emp;

	logic in_grid;
	logic old_bit;
	row_t wr_row;
	logic [STEP_W-1:0] wr_step;

	assign item.ready = (state_q == S_IDLE);
	assign in_fire    = item.valid && item.ready;
	assign slot_free  = !out_valid_q || result.ready;

	assign rdata   = rd_vld_q ? rdata_q : '0;
	assign in_grid = (int'(row_q) < GRID_SIZE) && (int'(col_q) < GRID_SIZE);
	assign old_bit = rdata[col_q[ADDR_W-1:0]];
	assign below   = (step_q <= ROWS) ? rdata : '0;
	assign wr_step = step_q - STEP_W'(2);

	always_comb begin
		wr_row = rdata;
		wr_row[col_q[ADDR_W-1:0]] = val_q;
	end

	lgs_row_rule u_rule (
		.above    (prev_q),
		.center   (cur_q),
		.below    (below),
		.next_row (next_row)
	);

	// memory port control and result selection
	always_comb begin
		mem_re  = 1'b0;
		mem_ra  = item.row[ADDR_W-1:0];
		mem_we  = 1'b0;
		mem_wa  = row_q[ADDR_W-1:0];
		mem_wd  = wr_row;
		load    = 1'b0;
		res_rd  = 1'b0;
		res_chg = 1'b0;
		res_emp = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				mem_re = in_fire && (op_t'(item.operation) == OP_READ
					|| op_t'(item.operation) == OP_WRITE);
			end
			S_READ: begin
				load   = slot_free;
				res_rd = in_grid && old_bit;
			end
			S_WRITE: begin
				load    = slot_free;
				res_chg = in_grid && (old_bit != val_q);
				mem_we  = slot_free && res_chg;
			end
			S_TICK: begin
				mem_ra = step_q[ADDR_W-1:0];
				mem_re = step_q < ROWS;
				// write back row step-2 once the window is full
				if (step_q >= STEP_W'(2) && (step_q != LAST_STEP || slot_free)) begin
					mem_we = 1'b1;
					mem_wa = wr_step[ADDR_W-1:0];
					mem_wd = next_row;
				end
				load    = (step_q == LAST_STEP) && slot_free;
				res_emp = !(live_q || (|next_row));
			end
			S_CLEAR: begin
				load    = slot_free;
				res_emp = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rdata_q <= mem_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (state_q == S_CLEAR && slot_free) begin
				row_vld_q <= '0;
			end else if (mem_we) begin
				row_vld_q[mem_wa] <= 1'b1;
			end
			if (mem_re) begin
				rd_vld_q <= row_vld_q[mem_ra];
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
			live_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						step_q <= '0;
						live_q <= 1'b0;
						case (op_t'(item.operation))
							OP_WRITE: state_q <= S_WRITE;
							OP_READ:  state_q <= S_READ;
							OP_TICK:  state_q <= S_TICK;
							default:  state_q <= S_CLEAR;
						endcase
					end
				end
				S_READ, S_WRITE, S_CLEAR: begin
					if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				S_TICK: begin
					if (step_q != LAST_STEP) begin
						step_q <= step_q + STEP_W'(1);
						if (step_q >= STEP_W'(2)) begin
							live_q <= live_q || (|next_row);
						end
					end else if (slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// capture the item; slide the three-row window during a tick
	always_ff @(posedge clk) begin
		if (in_fire) begin
			row_q <= item.row;
			col_q <= item.column;
			val_q <= item.cell_value;
		end
		if (state_q == S_TICK && step_q != LAST_STEP) begin
			if (step_q == '0) begin
				prev_q <= '0;
				cur_q  <= '0;
			end else begin
				prev_q <= cur_q;
				cur_q  <= below;
			end
		end
	end

	// output register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rd_value_q <= res_rd;
			chg_q      <= res_chg;
			emp_q      <= res_emp;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.read_value = rd_value_q;
	assign result.changed    = chg_q;
	assign result.grid_empty = emp_q;

endmodule

// ===== sim/life_grid_result_check.sv =====
// Result checker for the life grid generation step unit: watches both channels,
// predicts each result from its own grid copy and compares field by field.
// Depends on lgs_pkg and the lgs_in_if / lgs_out_if channel interfaces.
`timescale 1ns / 100ps

module life_grid_result_check (
	input  logic clk,
	input  logic arst_n,
	lgs_in_if    item,
	lgs_out_if   result,
	output int   mismatches,
	output int   outstanding
);
	import lgs_pkg::*;

	typedef struct packed {
		logic read_value;
		logic changed;
		logic grid_empty;
	} grid_result_t;

	row_t         grid_cells [GRID_SIZE];
	grid_result_t pending_results [$];
	grid_result_t want;
	grid_result_t got;
	int           results_seen;

	// Advance the grid copy one B3/S23 generation; dead beyond the edge.
	function automatic logic advance_generation();
		row_t nxt [GRID_SIZE];
		int   n;
		logic any_alive;
		any_alive = 1'b0;
		for (int r = 0; r < GRID_SIZE; r++) begin
			for (int c = 0; c < GRID_SIZE; c++) begin
				n = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						if ((dr != 0 || dc != 0) && r + dr >= 0 && r + dr < GRID_SIZE &&
								c + dc >= 0 && c + dc < GRID_SIZE)
							n += int'(grid_cells[r + dr][c + dc]);
					end
				end
				nxt[r][c] = (n == BIRTH_COUNT) || (grid_cells[r][c] && n == SURVIVE_COUNT);
				any_alive |= nxt[r][c];
			end
		end
		grid_cells = nxt;
		return !any_alive;
	endfunction

	task automatic report_bad_result(input string what, input grid_result_t exp_res,
			input grid_result_t act_res);
		mismatches++;
		if (mismatches <= 10)
			$display("[%0t] result %0d %s: expected rd=%b chg=%b emp=%b, got rd=%b chg=%b emp=%b",
				$realtime, results_seen, what, exp_res.read_value, exp_res.changed,
				exp_res.grid_empty, act_res.read_value, act_res.changed, act_res.grid_empty);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < GRID_SIZE; r++)
				grid_cells[r] = '0;
			pending_results.delete();
			mismatches   = 0;
			outstanding  <= 0;
			results_seen = 0;
		end else begin
			if (item.valid && item.ready) begin
				want = '0;
				case (op_t'(item.operation))
					OP_WRITE: begin
						if (item.row < GRID_SIZE && item.column < GRID_SIZE &&
								grid_cells[item.row][item.column] != item.cell_value) begin
							grid_cells[item.row][item.column] = item.cell_value;
							want.changed = 1'b1;
						end
					end
					OP_READ: begin
						if (item.row < GRID_SIZE && item.column < GRID_SIZE)
							want.read_value = grid_cells[item.row][item.column];
					end
					OP_TICK: want.grid_empty = advance_generation();
					OP_CLEAR: begin
						for (int r = 0; r < GRID_SIZE; r++)
							grid_cells[r] = '0;
						want.grid_empty = 1'b1;
					end
					default: ;
				endcase
				pending_results = {pending_results, want};
			end
			if (result.valid && result.ready) begin
				got = '{result.read_value, result.changed, result.grid_empty};
				if (pending_results.size() == 0) begin
					report_bad_result("arrived with nothing outstanding", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got !== want)
						report_bad_result("differs", want, got);
				end
				results_seen++;
			end
			outstanding <= pending_results.size();
		end
	end

endmodule

// ===== sim/life_grid_generation_step_unit_tb.sv =====
// Testbench top for life_grid_generation_step_unit: clock, reset, operation
// stimulus and result-side flow control; checking lives in life_grid_result_check.
// Depends on lgs_pkg, the channel interfaces and the block itself.
`timescale 1ns / 100ps

module life_grid_generation_step_unit_tb;
	import lgs_pkg::*;

	// A tick is the slowest item; even with every item a tick and both sides
	// stalling, 650-odd items stay far below this.
	localparam int CYCLE_LIMIT    = 200_000;
	localparam int ITEM_TARGET    = 650;
	localparam int IDLE_PERCENT   = 17;
	// sender runs without gaps over this item span
	localparam int STEADY_FIRST   = 300;
	localparam int STEADY_LAST    = 420;
	// receiver holds off once, long enough to back the block up into its input
	localparam int HOLD_AFTER     = 150;
	localparam int HOLD_CYCLES    = 400;
	// receiver runs without stalls over this cycle span
	localparam int RX_STEADY_FROM = 2000;
	localparam int RX_STEADY_TO   = 3500;

	logic clk;
	logic arst_n;
	int   cycle_count = 0;
	int   items_sent  = 0;
	int   mismatch_count;
	int   results_outstanding;
	int   hold_left;
	logic hold_done;

	lgs_in_if  item_ch ();
	lgs_out_if result_ch ();

	life_grid_generation_step_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch)
	);

	life_grid_result_check u_result_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item_ch),
		.result      (result_ch),
		.mismatches  (mismatch_count),
		.outstanding (results_outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Watchdog: count cycles and give up well past the slowest correct run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// Result-side flow control. Hold ready low for one long stretch once the
	// sender is well under way, so the output register fills and the block
	// stops taking items; keep a window with no stalls at all; otherwise drop
	// ready at random, IDLE_PERCENT percent of the time.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
			hold_left       <= 0;
			hold_done       <= 1'b0;
		end else if (hold_left != 0) begin
			result_ch.ready <= 1'b0;
			hold_left       <= hold_left - 1;
		end else if (!hold_done && items_sent >= HOLD_AFTER) begin
			result_ch.ready <= 1'b0;
			hold_left       <= HOLD_CYCLES;
			hold_done       <= 1'b1;
		end else if (cycle_count >= RX_STEADY_FROM && cycle_count < RX_STEADY_TO) begin
			result_ch.ready <= 1'b1;
		end else begin
			result_ch.ready <= ($urandom_range(99) >= IDLE_PERCENT);
		end
	end

	// Offer one operation item and hold it until the block takes it. A gap,
	// if any, comes first, so valid never gets two updates in one step and a
	// back-to-back item simply keeps valid high.
	task automatic send_item(input op_t op, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic v);
		int gap;
		gap = 0;
		if (!(items_sent >= STEADY_FIRST && items_sent < STEADY_LAST) &&
				$urandom_range(99) < IDLE_PERCENT)
			gap = $urandom_range(1, 5);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.operation  <= op;
		item_ch.row        <= r;
		item_ch.column     <= c;
		item_ch.cell_value <= v;
		item_ch.valid      <= 1'b1;
		do @(posedge clk); while (!item_ch.ready);
		items_sent++;
	endtask

	function automatic logic [COORD_W-1:0] any_coord();
		return COORD_W'($urandom_range(GRID_SIZE - 1));
	endfunction

	initial begin
		logic [COORD_W-1:0] base_r;
		logic [COORD_W-1:0] base_c;
		int                 span;
		int                 pick;
		op_t                noise_op;

		// Drive every input to a known value before anything else happens.
		arst_n               = 1'b0;
		item_ch.valid        = 1'b0;
		item_ch.operation    = OP_READ;
		item_ch.row          = '0;
		item_ch.column       = '0;
		item_ch.cell_value   = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: corners and field extremes, write of the stored value,
		// read ignoring cell_value, ticks on lone cells, an edge blinker and a
		// corner block, a clear with junk fields, and a tick of an empty grid.
		send_item(OP_READ,  5'd0,  5'd0,  1'b1);
		send_item(OP_WRITE, 5'd0,  5'd0,  1'b1);
		send_item(OP_WRITE, 5'd0,  5'd0,  1'b1);
		send_item(OP_READ,  5'd0,  5'd0,  1'b0);
		send_item(OP_WRITE, 5'd31, 5'd31, 1'b1);
		send_item(OP_WRITE, 5'd0,  5'd31, 1'b1);
		send_item(OP_WRITE, 5'd31, 5'd0,  1'b1);
		send_item(OP_READ,  5'd31, 5'd31, 1'b0);
		send_item(OP_WRITE, 5'd17, 5'd10, 1'b0);
		send_item(OP_TICK,  5'd31, 5'd31, 1'b1);
		send_item(OP_READ,  5'd31, 5'd0,  1'b1);
		send_item(OP_WRITE, 5'd0,  5'd5,  1'b1);
		send_item(OP_WRITE, 5'd0,  5'd6,  1'b1);
		send_item(OP_WRITE, 5'd0,  5'd7,  1'b1);
		send_item(OP_WRITE, 5'd30, 5'd30, 1'b1);
		send_item(OP_WRITE, 5'd30, 5'd31, 1'b1);
		send_item(OP_WRITE, 5'd31, 5'd30, 1'b1);
		send_item(OP_WRITE, 5'd31, 5'd31, 1'b1);
		send_item(OP_TICK,  5'd0,  5'd0,  1'b0);
		send_item(OP_READ,  5'd1,  5'd6,  1'b0);
		send_item(OP_TICK,  5'd21, 5'd10, 1'b1);
		send_item(OP_WRITE, 5'd0,  5'd6,  1'b0);
		send_item(OP_CLEAR, 5'd31, 5'd31, 1'b1);
		send_item(OP_READ,  5'd31, 5'd30, 1'b1);
		send_item(OP_TICK,  5'd10, 5'd21, 1'b0);

		// Random: mostly bursts of writes into a small window so that ticks
		// see real neighborhoods, followed by ticks with nearby reads; the
		// rest is scattered noise and the occasional clear.
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(99);
			if (pick < 70) begin
				base_r = any_coord();
				base_c = any_coord();
				span   = $urandom_range(3, 7);
				repeat ($urandom_range(4, 16))
					send_item(OP_WRITE, COORD_W'(base_r + $urandom_range(span - 1)),
						COORD_W'(base_c + $urandom_range(span - 1)), $urandom_range(99) < 70);
				repeat ($urandom_range(1, 4)) begin
					send_item(OP_TICK, any_coord(), any_coord(), 1'($urandom_range(1)));
					repeat ($urandom_range(0, 3))
						send_item(OP_READ, COORD_W'(base_r + $urandom_range(span)),
							COORD_W'(base_c + $urandom_range(span)), 1'($urandom_range(1)));
				end
			end else if (pick < 95) begin
				case ($urandom_range(2))
					0:       noise_op = OP_WRITE;
					1:       noise_op = OP_READ;
					default: noise_op = OP_TICK;
				endcase
				send_item(noise_op, any_coord(), any_coord(), 1'($urandom_range(1)));
			end else begin
				send_item(OP_CLEAR, any_coord(), any_coord(), 1'($urandom_range(1)));
			end
		end
		item_ch.valid <= 1'b0;

		// Let the last acceptance reach the checker, drain what is still
		// owed, then allow a tick's worth of cycles for anything stray.
		@(posedge clk);
		while (results_outstanding != 0) @(posedge clk);
		repeat (GRID_SIZE + 8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/lgs_pkg.sv
rtl/lgs_if.sv
rtl/lgs_row_rule.sv
rtl/life_grid_generation_step_unit.sv
sim/life_grid_result_check.sv
sim/life_grid_generation_step_unit_tb.sv
